### rtl/slu_pkg.sv
package slu_pkg;

    // Default size of the receive FIFO.
    localparam int FIFO_DEPTH_DEFAULT = 16;

    // Configuration register indexes.
    localparam logic CFG_REGISTER_BASE  = 1'b0;
    localparam logic CFG_RECEIVE_VECTOR = 1'b1;

    // Reset values of the configuration registers.
    localparam logic [15:0] REGISTER_BASE_RESET  = 16'o177560;
    localparam logic [8:0]  RECEIVE_VECTOR_RESET = 9'o060;

    // Operation codes of an input item.
    localparam logic [1:0] OP_READ    = 2'd0;
    localparam logic [1:0] OP_WRITE   = 2'd1;
    localparam logic [1:0] OP_RECEIVE = 2'd2;
    localparam logic [1:0] OP_TICK    = 2'd3;

    // Register offsets from the base address.
    localparam logic [15:0] RBUF_OFFSET = 16'd2;
    localparam logic [15:0] XCSR_OFFSET = 16'd4;
    localparam logic [15:0] XBUF_OFFSET = 16'd6;

    // Transmit vector lies this far above the receive vector.
    localparam logic [8:0] TX_VECTOR_OFFSET = 9'd4;

    // Status word bit positions.
    localparam int BIT_DONE   = 7;
    localparam int BIT_INT_EN = 6;
    localparam int BIT_ENABLE = 0;

    // Receive buffer word when the FIFO is empty: error plus overrun.
    localparam logic [15:0] RBUF_EMPTY_WORD = 16'hC000;

    // One input item.
    typedef struct packed {
        logic [1:0]  operation;
        logic [15:0] address;
        logic [15:0] write_data;
        logic [7:0]  line_byte;
        logic        bus_accepts;
    } in_item_t;

    // One result item.
    typedef struct packed {
        logic [15:0] read_data;
        logic        tx_valid;
        logic [7:0]  tx_byte;
        logic        irq_valid;
        logic [8:0]  irq_vector;
        logic        rx_dropped;
    } out_item_t;

    // Result of the first stage; pop_data selects the FIFO read data.
    typedef struct packed {
        out_item_t result;
        logic      pop_data;
    } stage_t;

endpackage

### rtl/slu_ram.sv
module slu_ram
    #(
        parameter int WIDTH  = 8,
        parameter int DEPTH  = 16,
        parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
    )
    (
        input  logic              clk,
        input  logic              wr_en,
        input  logic [ADDR_W-1:0] wr_addr,
        input  logic [WIDTH-1:0]  wr_data,
        input  logic              rd_en,
        input  logic [ADDR_W-1:0] rd_addr,
        output logic [WIDTH-1:0]  rd_data
    );

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // One write port and one registered read port; read data holds between reads.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### rtl/slu_ctrl.sv
module slu_ctrl
    import slu_pkg::*;
    #(
        parameter int FIFO_DEPTH = FIFO_DEPTH_DEFAULT,
        parameter int PTR_W      = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1
    )
    (
        input  logic             clk,
        input  logic             rst_n,
        input  logic             cfg_write,
        input  logic             cfg_index,
        input  logic [15:0]      cfg_data,
        input  logic             accept,
        input  in_item_t         item,
        output stage_t           stage,
        output logic             ram_wr_en,
        output logic [PTR_W-1:0] ram_wr_addr,
        output logic [7:0]       ram_wr_data,
        output logic             ram_rd_en,
        output logic [PTR_W-1:0] ram_rd_addr
    );

    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

    logic [15:0]      register_base_reg;
    logic [8:0]       receive_vector_reg;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             rx_done_reg, rx_done_next;
    logic             rx_int_en_reg, rx_int_en_next;
    logic             reader_en_reg, reader_en_next;
    logic             tx_ready_reg, tx_ready_next;
    logic             tx_int_en_reg, tx_int_en_next;
    logic             tx_break_reg, tx_break_next;
    logic [15:0]      tx_buffer_reg, tx_buffer_next;
    logic [8:0]       pending_reg, pending_next;

    logic [15:0]      addr_rcsr, addr_rbuf, addr_xcsr, addr_xbuf;
    logic [8:0]       tx_vector;
    logic [PTR_W-1:0] rd_ptr_inc, wr_ptr_inc;
    logic             req_valid;
    logic [8:0]       req_vector;

    // Register addresses and the transmit vector, all wrapping.
    assign addr_rcsr = register_base_reg;
    assign addr_rbuf = register_base_reg + RBUF_OFFSET;
    assign addr_xcsr = register_base_reg + XCSR_OFFSET;
    assign addr_xbuf = register_base_reg + XBUF_OFFSET;
    assign tx_vector = receive_vector_reg + TX_VECTOR_OFFSET;

    // Ring pointer increments.
    assign rd_ptr_inc = (rd_ptr_reg == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
    assign wr_ptr_inc = (wr_ptr_reg == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);

    // FIFO addresses come straight from the pointers. A push and a pop never fall
    // in the same cycle, so a pop that follows a push finds the pushed byte already in memory.
    assign ram_wr_addr = wr_ptr_reg;
    assign ram_wr_data = item.line_byte;
    assign ram_rd_addr = rd_ptr_reg;

    // Decode of one item: state updates, FIFO access and the result.
    always_comb
    begin
        rd_ptr_next    = rd_ptr_reg;
        wr_ptr_next    = wr_ptr_reg;
        count_next     = count_reg;
        rx_done_next   = rx_done_reg;
        rx_int_en_next = rx_int_en_reg;
        reader_en_next = reader_en_reg;
        tx_ready_next  = tx_ready_reg;
        tx_int_en_next = tx_int_en_reg;
        tx_break_next  = tx_break_reg;
        tx_buffer_next = tx_buffer_reg;
        pending_next   = pending_reg;
        req_valid      = 1'b0;
        req_vector     = '0;
        ram_wr_en      = 1'b0;
        ram_rd_en      = 1'b0;
        stage          = '0;

        if (accept)
        begin
            case (item.operation)
                OP_READ:
                begin
                    if (item.address == addr_rcsr)
                    begin
                        stage.result.read_data[BIT_DONE]   = rx_done_reg;
                        stage.result.read_data[BIT_INT_EN] = rx_int_en_reg;
                        stage.result.read_data[BIT_ENABLE] = reader_en_reg;
                    end
                    else if (item.address == addr_rbuf)
                    begin
                        if (count_reg != '0)
                        begin
                            ram_rd_en      = 1'b1;
                            stage.pop_data = 1'b1;
                            rd_ptr_next    = rd_ptr_inc;
                            count_next     = count_reg - CNT_W'(1);
                            if (count_next != '0)
                            begin
                                rx_done_next = 1'b1;
                                req_valid    = rx_int_en_reg;
                                req_vector   = receive_vector_reg;
                            end
                            else
                            begin
                                rx_done_next = 1'b0;
                            end
                        end
                        else
                        begin
                            stage.result.read_data = RBUF_EMPTY_WORD;
                        end
                    end
                    else if (item.address == addr_xcsr)
                    begin
                        stage.result.read_data[BIT_DONE]   = tx_ready_reg;
                        stage.result.read_data[BIT_INT_EN] = tx_int_en_reg;
                        stage.result.read_data[BIT_ENABLE] = tx_break_reg;
                    end
                    else if (item.address == addr_xbuf)
                    begin
                        stage.result.read_data = tx_buffer_reg;
                    end
                end
                OP_WRITE:
                begin
                    if (item.address == addr_rcsr)
                    begin
                        rx_int_en_next = item.write_data[BIT_INT_EN];
                        reader_en_next = item.write_data[BIT_ENABLE];
                        req_valid  = item.write_data[BIT_INT_EN] && !rx_int_en_reg && rx_done_reg;
                        req_vector = receive_vector_reg;
                    end
                    else if (item.address == addr_xcsr)
                    begin
                        tx_int_en_next = item.write_data[BIT_INT_EN];
                        tx_break_next  = item.write_data[BIT_ENABLE];
                        req_valid  = item.write_data[BIT_INT_EN] && !tx_int_en_reg && tx_ready_reg;
                        req_vector = tx_vector;
                    end
                    else if (item.address == addr_xbuf)
                    begin
                        tx_buffer_next        = item.write_data;
                        tx_ready_next         = 1'b1;
                        stage.result.tx_valid = 1'b1;
                        stage.result.tx_byte  = item.write_data[7:0];
                        req_valid             = tx_int_en_reg;
                        req_vector            = tx_vector;
                    end
                end
                OP_RECEIVE:
                begin
                    if (count_reg != CNT_W'(FIFO_DEPTH))
                    begin
                        ram_wr_en    = 1'b1;
                        wr_ptr_next  = wr_ptr_inc;
                        count_next   = count_reg + CNT_W'(1);
                        rx_done_next = 1'b1;
                        req_valid    = rx_int_en_reg;
                        req_vector   = receive_vector_reg;
                    end
                    else
                    begin
                        stage.result.rx_dropped = 1'b1;
                    end
                end
                OP_TICK:
                begin
                    if (pending_reg != '0 && item.bus_accepts)
                    begin
                        stage.result.irq_valid  = 1'b1;
                        stage.result.irq_vector = pending_reg;
                        pending_next            = '0;
                    end
                end
                default:
                begin
                end
            endcase

            // A request goes to the bus now, or replaces whatever is pending.
            if (req_valid)
            begin
                if (item.bus_accepts)
                begin
                    stage.result.irq_valid  = 1'b1;
                    stage.result.irq_vector = req_vector;
                end
                else
                begin
                    pending_next = req_vector;
                end
            end
        end
    end

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            register_base_reg  <= REGISTER_BASE_RESET;
            receive_vector_reg <= RECEIVE_VECTOR_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_REGISTER_BASE:  register_base_reg  <= cfg_data;
                CFG_RECEIVE_VECTOR: receive_vector_reg <= cfg_data[8:0];
                default:
                begin
                end
            endcase
        end
    end

    // Channel state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg    <= '0;
            wr_ptr_reg    <= '0;
            count_reg     <= '0;
            rx_done_reg   <= 1'b0;
            rx_int_en_reg <= 1'b0;
            reader_en_reg <= 1'b0;
            tx_ready_reg  <= 1'b1;
            tx_int_en_reg <= 1'b0;
            tx_break_reg  <= 1'b0;
            tx_buffer_reg <= '0;
            pending_reg   <= '0;
        end
        else
        begin
            rd_ptr_reg    <= rd_ptr_next;
            wr_ptr_reg    <= wr_ptr_next;
            count_reg     <= count_next;
            rx_done_reg   <= rx_done_next;
            rx_int_en_reg <= rx_int_en_next;
            reader_en_reg <= reader_en_next;
            tx_ready_reg  <= tx_ready_next;
            tx_int_en_reg <= tx_int_en_next;
            tx_break_reg  <= tx_break_next;
            tx_buffer_reg <= tx_buffer_next;
            pending_reg   <= pending_next;
        end
    end

endmodule

### rtl/serial_line_unit_registers_core.sv
// One serial line channel behind four word registers (receive status, receive
// buffer, transmit status, transmit buffer) at a configurable base. Each input
// transfer is a bus read, a bus write, a byte from the line or a tick, and gives
// exactly one result transfer. The unit takes one item every clock unless the
// input is stalled. As an item enters the first stage register, it is decoded,
// the control state is updated and the access to the receive FIFO memory is
// issued; the output register then collects the memory's registered read data.
// Received bytes are held in a single-port-pair RAM of FIFO_DEPTH bytes; its
// contents are unknown until written and need no clearing after reset. Input
// stall rises only while a result waits in the output register and the one
// behind it is also complete.
module serial_line_unit_registers_core
    import slu_pkg::*;
    #(
        parameter int FIFO_DEPTH = FIFO_DEPTH_DEFAULT
    )
    (
        input  logic        clk,
        input  logic        rst_n,
        input  logic        cfg_write,
        input  logic        cfg_index,
        input  logic [15:0] cfg_data,
        input  logic        in_valid,
        output logic        in_stall,
        input  in_item_t    in_item,
        output logic        out_valid,
        input  logic        out_stall,
        output out_item_t   out_item
    );

    localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;

    logic             in_accept;
    stage_t           stage;
    logic             ram_wr_en;
    logic [PTR_W-1:0] ram_wr_addr;
    logic [7:0]       ram_wr_data;
    logic             ram_rd_en;
    logic [PTR_W-1:0] ram_rd_addr;
    logic [7:0]       ram_rd_data;

    logic             s1_valid_reg;
    stage_t           s1_reg;
    logic             out_valid_reg;
    out_item_t        out_item_reg;
    out_item_t        out_item_next;
    logic             out_free;
    logic             s1_advance;

    // Handshake between the two stages and the output register.
    assign out_free   = !out_valid_reg || !out_stall;
    assign s1_advance = s1_valid_reg && out_free;
    assign in_stall   = s1_valid_reg && !out_free;
    assign in_accept  = in_valid && !in_stall;

    slu_ctrl
        #(
            .FIFO_DEPTH (FIFO_DEPTH),
            .PTR_W      (PTR_W)
        )
        u_ctrl
        (
            .clk         (clk),
            .rst_n       (rst_n),
            .cfg_write   (cfg_write),
            .cfg_index   (cfg_index),
            .cfg_data    (cfg_data),
            .accept      (in_accept),
            .item        (in_item),
            .stage       (stage),
            .ram_wr_en   (ram_wr_en),
            .ram_wr_addr (ram_wr_addr),
            .ram_wr_data (ram_wr_data),
            .ram_rd_en   (ram_rd_en),
            .ram_rd_addr (ram_rd_addr)
        );

    slu_ram
        #(
            .WIDTH  (8),
            .DEPTH  (FIFO_DEPTH),
            .ADDR_W (PTR_W)
        )
        u_fifo_ram
        (
            .clk     (clk),
            .wr_en   (ram_wr_en),
            .wr_addr (ram_wr_addr),
            .wr_data (ram_wr_data),
            .rd_en   (ram_rd_en),
            .rd_addr (ram_rd_addr),
            .rd_data (ram_rd_data)
        );

    // A popped byte replaces the read data once the memory has delivered it.
    always_comb
    begin
        out_item_next = s1_reg.result;
        if (s1_reg.pop_data)
        begin
            out_item_next.read_data = {8'b0, ram_rd_data};
        end
    end

    // Valid flags of the first stage and the output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_advance)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_reg <= stage;
        end
        if (s1_advance)
        begin
            out_item_reg <= out_item_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    // The FIFO memory is never read and written by the same item.
    assert property (@(posedge clk) disable iff (!rst_n)
        !(ram_rd_en && ram_wr_en))
        else $error("FIFO read and write issued together");

    // A FIFO read always lands in the first stage marked as a pop.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && ram_rd_en) |=> (s1_valid_reg && s1_reg.pop_data))
        else $error("FIFO read lost its stage");

    // Input is stalled only while both stages are held by the output stall.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (s1_valid_reg && out_valid_reg && out_stall))
        else $error("input stalled without a full pipeline");

    // While the first stage waits, no new FIFO read may disturb its data.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s1_advance) |-> !ram_rd_en)
        else $error("FIFO read data overwritten while held");

endmodule
